[hw/rtl/gbh_pkg.sv]
`default_nettype none

package gbh_pkg;

  // Wait counter width and the width used for limit compares
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TMO_WIDTH   = 16;
  localparam int unsigned SETTLE_WIDTH = 8;
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > TMO_WIDTH) ? COUNT_WIDTH : TMO_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 16;
  localparam int unsigned S_TDATA_WIDTH  = 24;
  localparam int unsigned S_TUSER_WIDTH  = 2;
  localparam int unsigned M_TDATA_WIDTH  = 24;

  localparam logic [7:0] DATA_RELEASED = 8'hFF;

  // Register reset values
  localparam logic [TMO_WIDTH-1:0]    SRC_TMO_RST  = 16'd1000;
  localparam logic [TMO_WIDTH-1:0]    ACC_TMO_RST  = 16'd100;
  localparam logic [TMO_WIDTH-1:0]    REL_WAIT_RST = 16'd1000;
  localparam logic [SETTLE_WIDTH-1:0] SETTLE_RST   = 8'd1;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SOURCE_TIMEOUT   = 2'd0,
    CFG_ACCEPTOR_TIMEOUT = 2'd1,
    CFG_RELEASE_WAIT     = 2'd2,
    CFG_SETTLE_TICKS     = 2'd3
  } cfg_idx_e;

  // Request kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SOURCE = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_S_RFD1   = 3'd1,
    PH_S_SETTLE = 3'd2,
    PH_S_DAC    = 3'd3,
    PH_S_RFD2   = 3'd4,
    PH_A_DAV    = 3'd5,
    PH_A_REL    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [TMO_WIDTH-1:0]    source_timeout;
    logic [TMO_WIDTH-1:0]    acceptor_timeout;
    logic [TMO_WIDTH-1:0]    release_wait;
    logic [SETTLE_WIDTH-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       tx_end;
    logic       nrfd_line;
    logic       ndac_line;
    logic       dav_line;
    logic       eoi_line;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    logic       dav;
    logic       nrfd;
    logic       ndac;
    logic       eoi;
    logic [7:0] data;
  } drives_t;

  typedef struct packed {
    drives_t    drv;
    logic       busy;
    logic       done;
    logic       status;
    logic [7:0] rx_byte;
    logic       rx_end;
  } result_t;

  localparam drives_t DRIVES_RELEASED = '{dav: 1'b1, nrfd: 1'b1, ndac: 1'b1, eoi: 1'b1,
                                          data: DATA_RELEASED};

endpackage

`default_nettype wire

[hw/rtl/gbh_cfg.sv]
`default_nettype none

module gbh_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [gbh_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  wire logic [gbh_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i,
  output gbh_pkg::cfg_t                            cfg_o
);
  import gbh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_TIMEOUT:   cfg_d.source_timeout   = cfg_wdata_i[TMO_WIDTH-1:0];
        CFG_ACCEPTOR_TIMEOUT: cfg_d.acceptor_timeout = cfg_wdata_i[TMO_WIDTH-1:0];
        CFG_RELEASE_WAIT:     cfg_d.release_wait     = cfg_wdata_i[TMO_WIDTH-1:0];
        CFG_SETTLE_TICKS:     cfg_d.settle_ticks     = cfg_wdata_i[SETTLE_WIDTH-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_timeout   <= SRC_TMO_RST;
      cfg_q.acceptor_timeout <= ACC_TMO_RST;
      cfg_q.release_wait     <= REL_WAIT_RST;
      cfg_q.settle_ticks     <= SETTLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/gbh_core.sv]
`default_nettype none

module gbh_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire gbh_pkg::cfg_t  cfg_i,
  input  wire gbh_pkg::item_t item_i,
  output gbh_pkg::result_t res_o
);
  import gbh_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0]             tx_q, tx_d;
  logic [7:0]             rx_q, rx_d;
  logic                   rx_end_q, rx_end_d;
  drives_t                drv_q, drv_d;
  logic                   done, status;

  logic [COUNT_WIDTH:0]   cnt_sum;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [TMO_WIDTH-1:0]   limit;
  logic                   timed_out;
  logic                   settled;

  // Saturating failed-tick count and its timeout test
  assign cnt_sum = {1'b0, cnt_q} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign cnt_inc = cnt_sum[COUNT_WIDTH] ? CNT_MAX : cnt_sum[COUNT_WIDTH-1:0];

  always_comb begin
    case (phase_q)
      PH_A_DAV: limit = cfg_i.acceptor_timeout;
      PH_A_REL: limit = cfg_i.release_wait;
      default:  limit = cfg_i.source_timeout;
    endcase
  end

  assign timed_out = (CMP_WIDTH'(cnt_inc) >= CMP_WIDTH'(limit)) || (cnt_inc == CNT_MAX);
  assign settled   = CMP_WIDTH'(cnt_inc) >= CMP_WIDTH'(cfg_i.settle_ticks);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.kind == KIND_SOURCE)      phase_d = PH_S_RFD1;
        else if (item_i.kind == KIND_ACCEPT) phase_d = PH_A_DAV;
      end
      PH_S_RFD1: begin
        if (item_i.nrfd_line) begin
          phase_d = (cfg_i.settle_ticks == '0) ? PH_S_DAC : PH_S_SETTLE;
        end else if (timed_out) begin
          phase_d = PH_IDLE;
        end
      end
      PH_S_SETTLE: begin
        if (settled) phase_d = PH_S_DAC;
      end
      PH_S_DAC: begin
        if (item_i.ndac_line)  phase_d = PH_S_RFD2;
        else if (timed_out)    phase_d = PH_IDLE;
      end
      PH_S_RFD2: begin
        if (item_i.nrfd_line || timed_out) phase_d = PH_IDLE;
      end
      PH_A_DAV: begin
        if (!item_i.dav_line) phase_d = PH_A_REL;
        else if (timed_out)   phase_d = PH_IDLE;
      end
      PH_A_REL: begin
        if (item_i.dav_line || timed_out) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Drives, counter and held bytes
  always_comb begin
    cnt_d    = cnt_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    rx_end_d = rx_end_q;
    drv_d    = drv_q;
    done     = 1'b0;
    status   = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.kind == KIND_SOURCE) begin
          drv_d     = DRIVES_RELEASED;
          drv_d.eoi = ~item_i.tx_end;
          tx_d      = item_i.tx_byte;
          cnt_d     = '0;
        end else if (item_i.kind == KIND_ACCEPT) begin
          drv_d      = DRIVES_RELEASED;
          drv_d.ndac = 1'b0;
          rx_d       = '0;
          rx_end_d   = 1'b0;
          cnt_d      = '0;
        end
      end
      PH_S_RFD1: begin
        if (item_i.nrfd_line) begin
          drv_d.data = ~tx_q;
          if (cfg_i.settle_ticks == '0) drv_d.dav = 1'b0;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
          if (timed_out) begin
            drv_d  = DRIVES_RELEASED;
            done   = 1'b1;
            status = 1'b1;
          end
        end
      end
      PH_S_SETTLE: begin
        if (settled) begin
          drv_d.dav = 1'b0;
          cnt_d     = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_S_DAC: begin
        if (item_i.ndac_line) begin
          drv_d.dav  = 1'b1;
          drv_d.data = DATA_RELEASED;
          cnt_d      = '0;
        end else begin
          cnt_d = cnt_inc;
          if (timed_out) begin
            drv_d  = DRIVES_RELEASED;
            done   = 1'b1;
            status = 1'b1;
          end
        end
      end
      PH_S_RFD2: begin
        if (item_i.nrfd_line) begin
          drv_d = DRIVES_RELEASED;
          done  = 1'b1;
        end else begin
          cnt_d = cnt_inc;
          if (timed_out) begin
            drv_d  = DRIVES_RELEASED;
            done   = 1'b1;
            status = 1'b1;
          end
        end
      end
      PH_A_DAV: begin
        if (!item_i.dav_line) begin
          drv_d.nrfd = 1'b0;
          drv_d.ndac = 1'b1;
          rx_d       = ~item_i.bus_data;
          rx_end_d   = ~item_i.eoi_line;
          cnt_d      = '0;
        end else begin
          cnt_d = cnt_inc;
          if (timed_out) begin
            drv_d  = DRIVES_RELEASED;
            done   = 1'b1;
            status = 1'b1;
          end
        end
      end
      PH_A_REL: begin
        if (!item_i.dav_line) cnt_d = cnt_inc;
        if (item_i.dav_line || timed_out) begin
          drv_d.ndac = 1'b0;
          done       = 1'b1;
        end
      end
      default: begin
        drv_d = DRIVES_RELEASED;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      tx_q     <= '0;
      rx_q     <= '0;
      rx_end_q <= 1'b0;
      drv_q    <= DRIVES_RELEASED;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      rx_end_q <= rx_end_d;
      drv_q    <= drv_d;
    end
  end

  assign res_o.drv     = drv_d;
  assign res_o.busy    = (phase_d != PH_IDLE);
  assign res_o.done    = done;
  assign res_o.status  = status;
  assign res_o.rx_byte = rx_d;
  assign res_o.rx_end  = rx_end_d;

endmodule

`default_nettype wire

[hw/rtl/gpib_byte_handshake.sv]
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: kind; tdata: tick request with sampled lines
// m_axis    out  tvalid/tready          tdata: line drives, busy/done/status, received byte
// cfg       in   cfg_we_i (no wait)     cfg_idx_i selects register, cfg_wdata_i value
//
// One request per clock sustained while m_axis_tready is high, one result per request: an
// input register feeds the state machine, which fills the result register as it steps.
// Async active-low reset: phase idle, lines released with data 0xFF, timeouts source
// 1000, acceptor 100, release 1000 ticks, settle 1 tick.
// While a result waits and m_axis_tready is low the result and the state machine hold,
// and the input register takes at most one more request before s_axis_tready drops.
module gpib_byte_handshake (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // tdata, low bit up: tx_byte[7:0], tx_end, nrfd_line, ndac_line, dav_line,
  // eoi_line, bus_data[7:0], 3 zero bits
  input  wire logic [gbh_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  wire logic [gbh_pkg::S_TUSER_WIDTH-1:0]   s_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata, low bit up: dav_drive, nrfd_drive, ndac_drive, eoi_drive, data_drive[7:0],
  // busy_res, done_res, status, rx_byte[7:0], rx_end
  output      logic [gbh_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [gbh_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  wire logic [gbh_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i
);
  import gbh_pkg::*;

  cfg_t    cfg;
  item_t   in_q, in_d;
  logic    in_vld_q, in_vld_d;
  result_t res, out_q;
  logic    out_vld_q, out_vld_d;
  logic    s_acc, advance;

  gbh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the state machine when a request sits in the input register and the
  // result register is empty or being drained this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Unpack the request
  assign in_d.kind      = s_axis_tuser[1:0];
  assign in_d.tx_byte   = s_axis_tdata[7:0];
  assign in_d.tx_end    = s_axis_tdata[8];
  assign in_d.nrfd_line = s_axis_tdata[9];
  assign in_d.ndac_line = s_axis_tdata[10];
  assign in_d.dav_line  = s_axis_tdata[11];
  assign in_d.eoi_line  = s_axis_tdata[12];
  assign in_d.bus_data  = s_axis_tdata[20:13];

  assign in_vld_d  = s_acc || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: input loads on accept, result on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_acc)   in_q  <= in_d;
    if (advance) out_q <= res;
  end

  gbh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.rx_end, out_q.rx_byte, out_q.status, out_q.done, out_q.busy,
                          out_q.drv.data, out_q.drv.eoi, out_q.drv.ndac, out_q.drv.nrfd,
                          out_q.drv.dav};

  // A finished transfer never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[13] && m_axis_tdata[12]))
    else $error("done reported while busy");

  // A timeout status only comes with done
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[13])
    else $error("status set without done");

  // Every timeout reported in status leaves all lines released
  a_timeout_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> (m_axis_tdata[11:0] == 12'hFFF))
    else $error("lines not released after timeout");

  // Input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  import gbh_pkg::*;

  // Kind code that the block treats as a plain tick
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycle budget for the whole run
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Result count at which the receiver holds off for a long stretch
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  // Request count after which the sender pauses until every result is back
  localparam int unsigned DRAIN_AT = 1100;

  // Shadow of the handshake engine: phase, wait counter, held bytes and drives
  typedef struct {
    phase_e      ph;
    int unsigned cnt;
    logic [7:0]  rx;
    logic        rx_end;
    logic [7:0]  tx;
    drives_t     drv;
  } hs_state_t;

  typedef struct {
    hs_state_t st;
    result_t   res;
  } hs_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [S_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_WIDTH-1:0]  s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [M_TDATA_WIDTH-1:0]  m_axis_tdata;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i = '0;

  // Register copy used by both the planner and the predictor
  cfg_t reg_cfg = '{source_timeout: SRC_TMO_RST, acceptor_timeout: ACC_TMO_RST,
                    release_wait: REL_WAIT_RST, settle_ticks: SETTLE_RST};

  hs_state_t   bus_state;    // predictor state, advanced on each accepted request
  hs_state_t   plan_state;   // planner state, advanced as requests are queued
  item_t       request_q[$];
  result_t     expected_drives_q[$];
  item_t       cur_req;
  result_t     want_res;

  bit          quiet = 1'b0;        // no idling on either side while set
  bit          drain_wait = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned cycles = 0;

  gpib_byte_handshake i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic hs_state_t idle_state();
    hs_state_t s;
    s.ph = PH_IDLE;
    s.cnt = 0;
    s.rx = 8'h00;
    s.rx_end = 1'b0;
    s.tx = 8'h00;
    s.drv = DRIVES_RELEASED;
    return s;
  endfunction

  // Count one failed wait tick, saturating at the top of the counter
  function automatic int unsigned bump_wait(int unsigned cnt);
    return (cnt + 1 > CNT_MAX) ? CNT_MAX : cnt + 1;
  endfunction

  // A wait expires once the failed ticks reach the limit or the counter saturates
  function automatic bit wait_expired(int unsigned cnt, logic [TMO_WIDTH-1:0] limit);
    return (cnt >= limit) || (cnt == CNT_MAX);
  endfunction

  // Advance the handshake by one tick and produce the line drives it shows
  function automatic hs_step_t handshake_tick(hs_state_t st, cfg_t c, item_t it);
    hs_step_t r;
    bit done;
    bit tmo;
    done = 1'b0;
    tmo = 1'b0;
    r.st = st;
    case (st.ph)
      PH_IDLE: begin
        if (it.kind == KIND_SOURCE) begin
          r.st.drv = DRIVES_RELEASED;
          r.st.drv.eoi = ~it.tx_end;
          r.st.tx = it.tx_byte;
          r.st.ph = PH_S_RFD1;
          r.st.cnt = 0;
        end else if (it.kind == KIND_ACCEPT) begin
          r.st.drv = DRIVES_RELEASED;
          r.st.drv.ndac = 1'b0;
          r.st.rx = 8'h00;
          r.st.rx_end = 1'b0;
          r.st.ph = PH_A_DAV;
          r.st.cnt = 0;
        end
      end
      PH_S_RFD1: begin
        if (it.nrfd_line) begin
          r.st.drv.data = ~st.tx;
          r.st.cnt = 0;
          if (c.settle_ticks == 0) begin
            r.st.drv.dav = 1'b0;
            r.st.ph = PH_S_DAC;
          end else begin
            r.st.ph = PH_S_SETTLE;
          end
        end else begin
          r.st.cnt = bump_wait(st.cnt);
          tmo = wait_expired(r.st.cnt, c.source_timeout);
        end
      end
      PH_S_SETTLE: begin
        r.st.cnt = st.cnt + 1;
        if (r.st.cnt >= c.settle_ticks) begin
          r.st.drv.dav = 1'b0;
          r.st.ph = PH_S_DAC;
          r.st.cnt = 0;
        end
      end
      PH_S_DAC: begin
        if (it.ndac_line) begin
          r.st.drv.dav = 1'b1;
          r.st.drv.data = DATA_RELEASED;
          r.st.ph = PH_S_RFD2;
          r.st.cnt = 0;
        end else begin
          r.st.cnt = bump_wait(st.cnt);
          tmo = wait_expired(r.st.cnt, c.source_timeout);
        end
      end
      PH_S_RFD2: begin
        if (it.nrfd_line) begin
          r.st.drv = DRIVES_RELEASED;
          r.st.ph = PH_IDLE;
          done = 1'b1;
        end else begin
          r.st.cnt = bump_wait(st.cnt);
          tmo = wait_expired(r.st.cnt, c.source_timeout);
        end
      end
      PH_A_DAV: begin
        if (!it.dav_line) begin
          // Data valid: not ready any more, latch the byte, acknowledge
          r.st.drv.nrfd = 1'b0;
          r.st.rx = ~it.bus_data;
          r.st.rx_end = ~it.eoi_line;
          r.st.drv.ndac = 1'b1;
          r.st.ph = PH_A_REL;
          r.st.cnt = 0;
        end else begin
          r.st.cnt = bump_wait(st.cnt);
          tmo = wait_expired(r.st.cnt, c.acceptor_timeout);
        end
      end
      PH_A_REL: begin
        // Running out of patience here still counts as a good transfer
        if (!it.dav_line) begin
          r.st.cnt = bump_wait(st.cnt);
        end
        if (it.dav_line || wait_expired(r.st.cnt, c.release_wait)) begin
          r.st.drv.ndac = 1'b0;
          r.st.ph = PH_IDLE;
          done = 1'b1;
        end
      end
      default: begin
        r.st.drv = DRIVES_RELEASED;
        r.st.ph = PH_IDLE;
        r.st.cnt = 0;
      end
    endcase
    if (tmo) begin
      r.st.drv = DRIVES_RELEASED;
      r.st.ph = PH_IDLE;
      done = 1'b1;
    end
    r.res.drv = r.st.drv;
    r.res.busy = (r.st.ph != PH_IDLE);
    r.res.done = done;
    r.res.status = tmo;
    r.res.rx_byte = r.st.rx;
    r.res.rx_end = r.st.rx_end;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  function automatic item_t mk_req(logic [1:0] kind, logic [7:0] tx, logic tx_end,
                                   logic nrfd, logic ndac, logic dav, logic eoi,
                                   logic [7:0] bus);
    item_t it;
    it.kind = kind;
    it.tx_byte = tx;
    it.tx_end = tx_end;
    it.nrfd_line = nrfd;
    it.ndac_line = ndac;
    it.dav_line = dav;
    it.eoi_line = eoi;
    it.bus_data = bus;
    return it;
  endfunction

  // Queue a request and step the planner so later requests can follow the phase
  task automatic queue_request(input item_t it);
    hs_step_t s;
    s = handshake_tick(plan_state, reg_cfg, it);
    plan_state = s.st;
    request_q.push_back(it);
  endtask

  function automatic item_t random_req(logic [1:0] kind);
    return mk_req(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed transfers: the line each wait looks at comes true after a
  // random number of ticks, or never when a timeout is wanted. Finish the open
  // transfer once the budget is spent.
  task automatic plan_requests(input int unsigned n, input bit allow_tmo);
    item_t       it;
    phase_e      seen;
    bit          force_tmo;
    bit          met;
    int unsigned met_pct;
    int unsigned k;
    int unsigned pick;
    seen = PH_IDLE;
    force_tmo = 1'b0;
    met_pct = 50;
    k = 0;
    while (k < n || plan_state.ph != PH_IDLE) begin
      it = random_req(KIND_TICK);
      if (plan_state.ph != seen) begin
        seen = plan_state.ph;
        force_tmo = allow_tmo && ($urandom_range(0, 5) == 0);
      end
      met = (k >= n) ? 1'b1 : (force_tmo ? 1'b0 : ($urandom_range(0, 99) < met_pct));
      case (plan_state.ph)
        PH_IDLE: begin
          pick = $urandom_range(0, 99);
          if (pick < 45) it.kind = KIND_SOURCE;
          else if (pick < 85) it.kind = KIND_ACCEPT;
          else if (pick < 95) it.kind = KIND_TICK;
          else it.kind = KIND_UNUSED;
          met_pct = $urandom_range(15, 95);
        end
        PH_S_RFD1, PH_S_RFD2: it.nrfd_line = met;
        PH_S_DAC: it.ndac_line = met;
        PH_A_DAV: it.dav_line = ~met;
        PH_A_REL: it.dav_line = met;
        default: ;
      endcase
      // Noise: a start in the middle of a transfer must be ignored
      if (plan_state.ph != PH_IDLE && $urandom_range(0, 9) == 0) begin
        it.kind = 2'($urandom_range(1, 3));
      end
      queue_request(it);
      k++;
    end
  endtask

  // Hold a whole waiting phase false until the engine gives up
  task automatic plan_stuck_wait();
    item_t it;
    while (plan_state.ph != PH_IDLE) begin
      it = random_req(KIND_TICK);
      it.nrfd_line = 1'b0;
      it.ndac_line = 1'b0;
      it.dav_line = (plan_state.ph == PH_A_DAV);
      queue_request(it);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [TMO_WIDTH-1:0] pick_limit();
    if ($urandom_range(0, 99) < 80) return TMO_WIDTH'($urandom_range(0, 6));
    return TMO_WIDTH'($urandom_range(7, 60));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and drain
  // ---------------------------------------------------------------------------

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Write all four registers; the settle word carries random upper bits that
  // the 8-bit register must drop
  task automatic apply_cfg(input logic [15:0] src, input logic [15:0] acc,
                           input logic [15:0] rel, input logic [7:0] settle);
    logic [15:0] settle_word;
    settle_word = {8'($urandom_range(0, 255)), settle};
    write_reg(CFG_SOURCE_TIMEOUT, src);
    write_reg(CFG_ACCEPTOR_TIMEOUT, acc);
    write_reg(CFG_RELEASE_WAIT, rel);
    write_reg(CFG_SETTLE_TICKS, settle_word);
    reg_cfg.source_timeout = src;
    reg_cfg.acceptor_timeout = acc;
    reg_cfg.release_wait = rel;
    reg_cfg.settle_ticks = settle_word[7:0];
  endtask

  // Advance until every queued request went in and every result came back
  task automatic wait_drained();
    while (request_q.size() != 0 || s_axis_tvalid || expected_drives_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------

  initial begin
    bus_state = idle_state();
    plan_state = idle_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the registers first
    plan_requests(150, 1'b1);
    wait_drained();

    // Directed: zero settle, zero acceptor timeout, tight source and release limits
    apply_cfg(16'd2, 16'd0, 16'd1, 8'd0);
    queue_request(mk_req(KIND_SOURCE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    // ready: data goes out and DAV drops on the same tick
    queue_request(mk_req(KIND_TICK, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
    // source stuck on not-ready until the timeout
    queue_request(mk_req(KIND_SOURCE, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF));
    // acceptor takes 0x00 on the bus with EOI low, then the release wait runs out
    queue_request(mk_req(KIND_ACCEPT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
    // zero acceptor timeout: the first tick without DAV gives up
    queue_request(mk_req(KIND_ACCEPT, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
    // start while busy is ignored; DAV high finishes the byte
    queue_request(mk_req(KIND_ACCEPT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_SOURCE, 8'h33, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_UNUSED, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
    // source after an acceptor: releases NDAC and NRFD; NDAC never comes
    queue_request(mk_req(KIND_SOURCE, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
    // source stuck on the second not-ready wait
    queue_request(mk_req(KIND_SOURCE, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    wait_drained();

    // Top of every register: longest limits and the longest settle time
    quiet = 1'b1;
    apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_request(random_req(KIND_SOURCE));
    plan_requests(20, 1'b0);
    queue_request(random_req(KIND_ACCEPT));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h96));
    plan_requests(20, 1'b0);
    wait_drained();

    // Bottom of every register, then all ones
    quiet = 1'b0;
    apply_cfg(16'd0, 16'd0, 16'd0, 8'd0);
    plan_requests(150, 1'b1);
    wait_drained();
    apply_cfg(16'd1, 16'd1, 16'd1, 8'd1);
    // every wait held false until it gives up
    queue_request(random_req(KIND_SOURCE));
    plan_stuck_wait();
    queue_request(random_req(KIND_ACCEPT));
    plan_stuck_wait();
    queue_request(random_req(KIND_ACCEPT));
    queue_request(mk_req(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h3C));
    plan_stuck_wait();
    plan_requests(150, 1'b1);
    wait_drained();

    // Random settings; some phases run without idling
    repeat (7) begin
      quiet = ($urandom_range(0, 2) == 0);
      apply_cfg(pick_limit(), pick_limit(), pick_limit(), 8'($urandom_range(0, 5)));
      plan_requests(130, 1'b1);
      wait_drained();
    end

    quiet = 1'b0;
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("gpib_byte_handshake: match");
    end else begin
      $display("gpib_byte_handshake: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests, predict each accepted one
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
      drain_wait <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hs_step_t s;
        s = handshake_tick(bus_state, reg_cfg, cur_req);
        bus_state = s.st;
        expected_drives_q.push_back(s.res);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until the block takes it
      end else if (drain_wait) begin
        s_axis_tvalid <= 1'b0;
        if (expected_drives_q.size() == 0) drain_wait <= 1'b0;
      end else if (src_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        s_axis_tuser <= cur_req.kind;
        s_axis_tdata <= {3'b000, cur_req.bus_data, cur_req.eoi_line, cur_req.dav_line,
                         cur_req.ndac_line, cur_req.nrfd_line, cur_req.tx_end,
                         cur_req.tx_byte};
        s_axis_tvalid <= 1'b1;
        src_gap <= quiet ? 0 : pick_gap();
        n_sent++;
        // pause once, mid-run, until every outstanding result is back
        if (n_sent == DRAIN_AT) drain_wait <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction, stall at random
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (n_errors < 30) begin
      $display("result %0d: %s got %0h want %0h", n_results, what, got, want);
    end
    n_errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drives_q.size() == 0) begin
          report("result with nothing pending", 32'(m_axis_tdata), 32'd0);
        end else begin
          want_res = expected_drives_q.pop_front();
          check_field("dav_drive", 32'(m_axis_tdata[0]), 32'(want_res.drv.dav));
          check_field("nrfd_drive", 32'(m_axis_tdata[1]), 32'(want_res.drv.nrfd));
          check_field("ndac_drive", 32'(m_axis_tdata[2]), 32'(want_res.drv.ndac));
          check_field("eoi_drive", 32'(m_axis_tdata[3]), 32'(want_res.drv.eoi));
          check_field("data_drive", 32'(m_axis_tdata[11:4]), 32'(want_res.drv.data));
          check_field("busy", 32'(m_axis_tdata[12]), 32'(want_res.busy));
          check_field("done", 32'(m_axis_tdata[13]), 32'(want_res.done));
          check_field("status", 32'(m_axis_tdata[14]), 32'(want_res.status));
          check_field("rx_byte", 32'(m_axis_tdata[22:15]), 32'(want_res.rx_byte));
          check_field("rx_end", 32'(m_axis_tdata[23]), 32'(want_res.rx_end));
        end
        n_results++;
      end
      if (!long_hold_done && n_results >= HOLD_AT) begin
        // long hold-off: the sender keeps offering so the input side backs up
        long_hold_done <= 1'b1;
        sink_stall <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall <= quiet ? 0 : pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gpib_byte_handshake: mismatch");
      $finish;
    end
  end

endmodule

`default_nettype wire
